FILE: rtl/core/fpba_pkg.sv
// Shared constants, codes and types for the fit policy block allocator.
package fpba_pkg;

    // Table geometry.
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_WIDTH = 16;

    // Field widths of the ports.
    localparam int ACT_W   = 1;
    localparam int BIDX_W  = 4;
    localparam int FSIZE_W = 16;
    localparam int POL_W   = 2;
    localparam int BCNT_W  = 5;
    localparam int CIDX_W  = 1;
    localparam int CDATA_W = 5;

    // Internal widths that follow from the table geometry.
    localparam int ADDR_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CNT_W  = $clog2(NUM_BLOCKS + 1);

    // Item kinds.
    localparam logic [ACT_W-1:0] ACT_LOAD    = 1'b0;
    localparam logic [ACT_W-1:0] ACT_REQUEST = 1'b1;

    // Placement policies; the unused code behaves as first fit.
    localparam logic [POL_W-1:0] POL_FIRST = 2'd0;
    localparam logic [POL_W-1:0] POL_BEST  = 2'd1;
    localparam logic [POL_W-1:0] POL_WORST = 2'd2;

    // Configuration register indexes.
    localparam logic [CIDX_W-1:0] CFG_POLICY      = 1'b0;
    localparam logic [CIDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

    // Configuration as seen by the search engine.
    typedef struct packed {
        logic [POL_W-1:0] policy;
        logic [CNT_W-1:0] active;
    } cfg_t;

    // One result beat.
    typedef struct packed {
        logic               granted;
        logic [BIDX_W-1:0]  chosen_block;
        logic [FSIZE_W-1:0] remaining;
    } res_t;

endpackage

FILE: rtl/core/fpba_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
module fpba_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/fpba_engine.sv
// Search engine: scans the free-size memory one block a cycle and writes back the choice.
module fpba_engine (
    input  logic                          clk,
    input  logic                          rst_n,
    input  fpba_pkg::cfg_t                cfg,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [fpba_pkg::ACT_W-1:0]    action,
    input  logic [fpba_pkg::BIDX_W-1:0]   block_index,
    input  logic [fpba_pkg::FSIZE_W-1:0]  size,
    output logic                          res_valid,
    input  logic                          res_ready,
    output fpba_pkg::res_t                res
);

    import fpba_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_SCAN  = 2'd1;
    localparam logic [1:0] S_WRITE = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_W-1:0]      issue_reg, issue_next;
    logic [CNT_W-1:0]      active_reg, active_next;
    logic                  pend_reg, pend_next;
    logic                  found_reg, found_next;
    logic [ADDR_W-1:0]     rd_idx_reg, rd_idx_next;
    logic [ADDR_W-1:0]     pick_reg, pick_next;
    logic [SIZE_WIDTH-1:0] best_reg, best_next;
    logic [SIZE_WIDTH-1:0] req_reg, req_next;

    logic                  mem_we, mem_re;
    logic [ADDR_W-1:0]     mem_waddr, mem_raddr;
    logic [SIZE_WIDTH-1:0] mem_wdata, mem_rdata;

    logic                  accept;
    logic                  load_in_range;
    logic [SIZE_WIDTH-1:0] in_size;
    logic                  fits, better;
    logic [SIZE_WIDTH-1:0] after_size;

    fpba_ram #(
        .WIDTH (SIZE_WIDTH),
        .DEPTH (NUM_BLOCKS)
    ) u_free_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    // Input decoding.
    assign in_ready      = (state_reg == S_IDLE) && res_ready;
    assign accept        = in_valid && in_ready;
    assign in_size       = SIZE_WIDTH'(size);
    assign load_in_range = (32'(block_index) < NUM_BLOCKS);

    // Candidate evaluation on the block that was read in the previous cycle.
    assign fits = (mem_rdata >= req_reg);
    always_comb
    begin
        better = 1'b0;
        unique case (cfg.policy)
            POL_BEST:  better = (mem_rdata < best_reg);
            POL_WORST: better = (mem_rdata > best_reg);
            default:   better = 1'b0;
        endcase
    end

    assign after_size = best_reg - req_reg;

    // Sequencer, memory control and result formation.
    always_comb
    begin
        state_next  = state_reg;
        issue_next  = issue_reg;
        active_next = active_reg;
        pend_next   = 1'b0;
        found_next  = found_reg;
        rd_idx_next = rd_idx_reg;
        pick_next   = pick_reg;
        best_next   = best_reg;
        req_next    = req_reg;
        mem_we      = 1'b0;
        mem_waddr   = ADDR_W'(block_index);
        mem_wdata   = in_size;
        mem_re      = 1'b0;
        mem_raddr   = issue_reg[ADDR_W-1:0];
        res_valid   = 1'b0;
        res         = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (action == ACT_LOAD)
                    begin
                        // A load with an index in range writes straight away; every load reports at once.
                        res_valid = 1'b1;
                        if (load_in_range)
                        begin
                            mem_we           = 1'b1;
                            res.granted      = 1'b1;
                            res.chosen_block = block_index;
                            res.remaining    = FSIZE_W'(in_size);
                        end
                    end
                    else if (cfg.active == '0)
                    begin
                        // No block takes part, so the request fails at once.
                        res_valid = 1'b1;
                    end
                    else
                    begin
                        state_next  = S_SCAN;
                        issue_next  = '0;
                        active_next = cfg.active;
                        found_next  = 1'b0;
                        req_next    = in_size;
                    end
                end
            end

            S_SCAN:
            begin
                // Issue the next read while blocks remain.
                if (issue_reg < active_reg)
                begin
                    mem_re      = 1'b1;
                    issue_next  = issue_reg + 1'b1;
                    pend_next   = 1'b1;
                    rd_idx_next = issue_reg[ADDR_W-1:0];
                end
                // Judge the block read in the previous cycle.
                if (pend_reg && fits && (!found_reg || better))
                begin
                    found_next = 1'b1;
                    pick_next  = rd_idx_reg;
                    best_next  = mem_rdata;
                end
                if ((issue_reg == active_reg) && !pend_reg)
                begin
                    state_next = S_WRITE;
                end
            end

            S_WRITE:
            begin
                // Write back the chosen block, if one was found, and report.
                res_valid = 1'b1;
                if (found_reg)
                begin
                    mem_waddr        = pick_reg;
                    mem_wdata        = after_size;
                    res.granted      = 1'b1;
                    res.chosen_block = BIDX_W'(pick_reg);
                    res.remaining    = FSIZE_W'(after_size);
                end
                if (res_ready)
                begin
                    mem_we     = found_reg;
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pend_reg  <= 1'b0;
            found_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            found_reg <= found_next;
        end
    end

    // Working registers of the scan.
    always_ff @(posedge clk)
    begin
        issue_reg  <= issue_next;
        active_reg <= active_next;
        rd_idx_reg <= rd_idx_next;
        pick_reg   <= pick_next;
        best_reg   <= best_next;
        req_reg    <= req_next;
    end

endmodule

FILE: rtl/core/fit_policy_block_allocator.sv
// Top level of the fit policy block allocator: configuration registers and result register.
//
// The allocator keeps the free size of each of 16 memory blocks in a small synchronous
// memory. A load beat (action 0) writes one block's size and returns its result through
// the output register. A request beat (action 1) is placed under the configured policy:
// first fit, best fit or worst fit, with ties to the lowest index. The engine reads one
// block per cycle from the memory's single read port, and the read data is registered in
// the memory. After the last block has been judged, the engine leaves the scan state once
// no read is pending and then writes back. The chosen block is written back at the same
// edge at which the result is registered. The engine takes the next beat only after it
// has returned to idle, so a request beat is finished before the next is taken. A result
// that is held at the output also holds off the next beat. Free sizes are not defined
// until loaded, so every block taking part in a search must have been loaded first.
// Configuration is to be written through the cfg port only while no item is in flight;
// the block itself does not enforce this.
module fit_policy_block_allocator (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [fpba_pkg::ACT_W-1:0]     action,
    input  logic [fpba_pkg::BIDX_W-1:0]    block_index,
    input  logic [fpba_pkg::FSIZE_W-1:0]   size,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic                           granted,
    output logic [fpba_pkg::BIDX_W-1:0]    chosen_block,
    output logic [fpba_pkg::FSIZE_W-1:0]   remaining,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [fpba_pkg::CIDX_W-1:0]    cfg_index,
    input  logic [fpba_pkg::CDATA_W-1:0]   cfg_data
);

    import fpba_pkg::*;

    logic [POL_W-1:0]  policy_reg, policy_next;
    logic [BCNT_W-1:0] bcount_reg, bcount_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg;
    cfg_t              cfg;
    logic              res_valid, res_ready;
    res_t              res;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_comb
    begin
        policy_next = policy_reg;
        bcount_next = bcount_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_POLICY:      policy_next = POL_W'(cfg_data);
                CFG_BLOCK_COUNT: bcount_next = BCNT_W'(cfg_data);
                default:         policy_next = policy_reg;
            endcase
        end
    end

    // Active block count saturated to the table size.
    assign cfg.policy = policy_reg;
    assign cfg.active = (32'(bcount_reg) > NUM_BLOCKS) ? CNT_W'(NUM_BLOCKS)
                                                      : CNT_W'(bcount_reg);

    fpba_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .block_index (block_index),
        .size        (size),
        .res_valid   (res_valid),
        .res_ready   (res_ready),
        .res         (res)
    );

    // Output register: a new result may enter when the slot is empty or being drained.
    assign res_ready      = !out_valid_reg || out_ready;
    assign out_valid_next = res_valid || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            policy_reg    <= POL_FIRST;
            bcount_reg    <= BCNT_W'(16);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            policy_reg    <= policy_next;
            bcount_reg    <= bcount_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_reg <= res;
        end
    end

    assign out_valid    = out_valid_reg;
    assign granted      = out_reg.granted;
    assign chosen_block = out_reg.chosen_block;
    assign remaining    = out_reg.remaining;

endmodule
